>>> rtl/core/bdmc_pkg.sv
// ----------------------------------------------------------------------------
// bdmc_pkg
// Shared types and constants for the button debounce / motor command core.
// ----------------------------------------------------------------------------
package bdmc_pkg;

  // Hold timer time base
  localparam int unsigned TICK_STEP_MS = 10;
  localparam int unsigned TIMER_W      = 12;
  localparam int unsigned COUNT_W      = 23;
  localparam int unsigned POS_W        = 24;

  localparam logic [TIMER_W-1:0] TICK_STEP  = TIMER_W'(TICK_STEP_MS);
  localparam logic [TIMER_W-1:0] TIMER_MAX  = '1;

  // Configuration register map
  typedef enum logic [1:0] {
    CFG_DEBOUNCE_THRESHOLD = 2'd0,
    CFG_WINDOW_FULL_COUNT  = 2'd1,
    CFG_WINDOW_MARGIN      = 2'd2,
    CFG_DOOR_MARGIN        = 2'd3
  } cfg_index_t;

  localparam logic [TIMER_W-1:0] THRESHOLD_RESET   = TIMER_W'(50);
  localparam logic [COUNT_W-1:0] FULL_COUNT_RESET  = COUNT_W'(100000);
  localparam logic [COUNT_W-1:0] WINDOW_MARGIN_RST = COUNT_W'(100);
  localparam logic [COUNT_W-1:0] DOOR_MARGIN_RST   = COUNT_W'(100);

  // Motor commands
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_STOP   = 2'd1,
    ACT_CLOSED = 2'd2,
    ACT_OPEN   = 2'd3
  } action_t;

endpackage

>>> rtl/core/bdmc_debounce.sv
// ----------------------------------------------------------------------------
// bdmc_debounce
// One button channel: saturating hold timer plus a one-pulse-per-hold latch.
// ----------------------------------------------------------------------------
module bdmc_debounce (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         level,
  input  logic [bdmc_pkg::TIMER_W-1:0] threshold,
  output logic                         pulse
);
  import bdmc_pkg::*;

  logic [TIMER_W-1:0] timer;
  logic [TIMER_W-1:0] timer_next;
  logic               latched;
  logic               latched_next;
  logic [TIMER_W:0]   sum;

  assign sum = {1'b0, timer} + {1'b0, TICK_STEP};

  always_comb begin
    timer_next   = '0;
    latched_next = 1'b0;
    pulse        = 1'b0;
    if (level) begin
      timer_next = timer;
      if (timer < threshold) begin
        timer_next = sum[TIMER_W] ? TIMER_MAX : sum[TIMER_W-1:0];
      end
      latched_next = latched;
      if ((timer_next >= threshold) && !latched) begin
        pulse        = 1'b1;
        latched_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer   <= '0;
      latched <= 1'b0;
    end else if (step) begin
      timer   <= timer_next;
      latched <= latched_next;
    end
  end

endmodule

>>> rtl/core/button_debounce_motor_command_core.sv
// ----------------------------------------------------------------------------
// button_debounce_motor_command_core
// Debounces window up/down and door buttons and turns presses into motor
// commands, one result per 10 ms tick item.
// ----------------------------------------------------------------------------
// Each input transfer is one timer tick; each tick gives exactly one output
// transfer with the three press pulses and the window and door commands.
// The core is a two-register pipeline (input register, result register), so
// a tick enters every cycle unless the input is stalled. Its result passes from
// the input register into the result register and transfers when the output
// side is not stalled. The throughput is one tick per cycle while the output
// is not stalled; the hold timers update between the two registers. The input
// stalls only while both registers are full and the output is stalled.
// Configuration writes are accepted at any time (cfg_ready is tied high) but
// must only be issued while the core is idle.
module button_debounce_motor_command_core (
  input  logic                         clk,
  input  logic                         rst,
  // tick input
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         up_pressed,
  input  logic                         down_pressed,
  input  logic                         door_pressed,
  input  logic                         window_running,
  input  logic                         door_running,
  input  logic signed [bdmc_pkg::POS_W-1:0] window_position,
  input  logic signed [bdmc_pkg::POS_W-1:0] door_position,
  // result output
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         up_press_pulse,
  output logic                         down_press_pulse,
  output logic                         door_press_pulse,
  output logic [1:0]                   window_action,
  output logic [1:0]                   door_action,
  // configuration writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  bdmc_pkg::cfg_index_t         cfg_index,
  input  logic [bdmc_pkg::COUNT_W-1:0] cfg_data
);
  import bdmc_pkg::*;

  // Compare width: positions are 24b signed, counts 23b unsigned, so sums
  // and differences fit in 26b signed with room to spare.
  localparam int unsigned CMP_W = POS_W + 2;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [TIMER_W-1:0] threshold;
  logic [COUNT_W-1:0] full_count;
  logic [COUNT_W-1:0] window_margin;
  logic [COUNT_W-1:0] door_margin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= THRESHOLD_RESET;
      full_count    <= FULL_COUNT_RESET;
      window_margin <= WINDOW_MARGIN_RST;
      door_margin   <= DOOR_MARGIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEBOUNCE_THRESHOLD: threshold     <= cfg_data[TIMER_W-1:0];
        CFG_WINDOW_FULL_COUNT:  full_count    <= cfg_data;
        CFG_WINDOW_MARGIN:      window_margin <= cfg_data;
        CFG_DOOR_MARGIN:        door_margin   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: input register (s1) feeds the result register.
  // --------------------------------------------------------------------------
  logic s1_valid;
  logic out_adv;
  logic s1_adv;

  assign out_adv  = !out_valid || out_ready;   // result register can load
  assign s1_adv   = s1_valid && out_adv;       // s1 item moves to result
  assign in_ready = !s1_valid || out_adv;

  // Input register payload
  logic                     s1_up;
  logic                     s1_down;
  logic                     s1_door;
  logic                     s1_win_run;
  logic                     s1_door_run;
  logic signed [POS_W-1:0]  s1_wpos;
  logic signed [POS_W-1:0]  s1_dpos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_up       <= up_pressed;
      s1_down     <= down_pressed;
      s1_door     <= door_pressed;
      s1_win_run  <= window_running;
      s1_door_run <= door_running;
      s1_wpos     <= window_position;
      s1_dpos     <= door_position;
    end
  end

  // --------------------------------------------------------------------------
  // Debounce channels: timers advance once per tick, as the tick leaves s1.
  // --------------------------------------------------------------------------
  logic up_p;
  logic down_p;
  logic door_p;

  bdmc_debounce u_deb_up (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_adv),
    .level     (s1_up),
    .threshold (threshold),
    .pulse     (up_p)
  );

  bdmc_debounce u_deb_down (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_adv),
    .level     (s1_down),
    .threshold (threshold),
    .pulse     (down_p)
  );

  bdmc_debounce u_deb_door (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_adv),
    .level     (s1_door),
    .threshold (threshold),
    .pulse     (door_p)
  );

  // --------------------------------------------------------------------------
  // Command decisions
  // --------------------------------------------------------------------------
  logic signed [CMP_W-1:0] wpos_x;
  logic signed [CMP_W-1:0] dpos_x;
  logic signed [CMP_W-1:0] open_limit;   // full_count - window_margin
  logic signed [CMP_W-1:0] wpos_plus_m;  // wpos + window_margin
  logic signed [CMP_W-1:0] door_m_x;
  logic                    below_open;
  logic                    above_closed;
  logic                    door_is_open;
  action_t                 up_act;
  action_t                 down_act;
  action_t                 win_act;
  action_t                 door_act;

  assign wpos_x      = CMP_W'(s1_wpos);
  assign dpos_x      = CMP_W'(s1_dpos);
  assign open_limit  = signed'(CMP_W'(full_count)) - signed'(CMP_W'(window_margin));
  assign wpos_plus_m = wpos_x + signed'(CMP_W'(window_margin));
  assign door_m_x    = signed'(CMP_W'(door_margin));

  assign below_open   = wpos_x < open_limit;
  assign above_closed = wpos_plus_m > signed'(CMP_W'(0));  // wpos > -margin
  assign door_is_open = dpos_x > door_m_x;

  always_comb begin
    down_act = ACT_NONE;
    up_act   = ACT_NONE;
    door_act = ACT_NONE;
    if (down_p) begin
      if (s1_win_run) begin
        down_act = ACT_STOP;
      end else if (below_open) begin
        down_act = ACT_OPEN;
      end
    end
    if (up_p) begin
      if (s1_win_run) begin
        up_act = ACT_STOP;
      end else if (above_closed) begin
        up_act = ACT_CLOSED;
      end
    end
    // up wins when both buttons fire and up has something to do
    win_act = (up_act != ACT_NONE) ? up_act : down_act;
    if (door_p) begin
      if (s1_door_run) begin
        door_act = ACT_STOP;
      end else if (door_is_open) begin
        door_act = ACT_CLOSED;
      end else begin
        door_act = ACT_OPEN;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      up_press_pulse   <= up_p;
      down_press_pulse <= down_p;
      door_press_pulse <= door_p;
      window_action    <= win_act;
      door_action      <= door_act;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A window command only comes from a window press.
  a_win_needs_press: assert property (@(posedge clk) disable iff (rst)
    out_valid && (window_action != ACT_NONE) |-> up_press_pulse || down_press_pulse)
    else $error("window command without a window press");

  // A door press always yields a door command, and only a press does.
  a_door_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (door_press_pulse == (door_action != ACT_NONE)))
    else $error("door command does not match door press");

  // A tick held in s1 behind a stalled result is not dropped.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_adv |=> s1_valid)
    else $error("tick lost from input register");

  // A result transfer with s1 empty and no new tick leaves the output empty.
  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !s1_valid |=> !out_valid)
    else $error("result repeated after transfer");

endmodule
